### design/dsi_pkg.sv
package dsi_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_PROBE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        logic [1:0] action;
        t_value     value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        t_value     echo_value;
    } t_out_item;

    typedef struct packed {
        logic   vld;
        logic   is_ins;
        logic   hit;
        logic   placed;
        t_value val;
    } t_tok;

    typedef struct packed {
        logic clr_all;
        logic fin;
        logic cancel;
    } t_bcast;

endpackage

### design/dsi_cell.sv
module dsi_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dsi_pkg::t_tok   i_tok,
    input  dsi_pkg::t_bcast i_bc,
    output dsi_pkg::t_tok   o_tok
);
    import dsi_pkg::*;

    t_value r_val;
    logic   r_valid;
    logic   r_pend;
    t_tok   r_tok;

    t_value n_val;
    logic   n_valid;
    logic   n_pend;
    t_tok   n_tok;
    logic   w_eq;

    assign w_eq = r_valid && (r_val == i_tok.val);

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        n_pend  = r_pend;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            if (w_eq && !i_tok.hit) begin
                n_tok.hit = 1'b1;
                if (!i_tok.is_ins) begin
                    n_valid = 1'b0;
                end
            end else if (i_tok.is_ins && !r_valid && !i_tok.placed && !i_tok.hit) begin
                n_val        = i_tok.val;
                n_valid      = 1'b1;
                n_pend       = 1'b1;
                n_tok.placed = 1'b1;
            end
        end
        if (i_bc.fin) begin
            n_pend = 1'b0;
            if (r_pend && i_bc.cancel) begin
                n_valid = 1'b0;
            end
        end
        if (i_bc.clr_all) begin
            n_valid = 1'b0;
            n_pend  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### design/distinct_set_intersection.sv
// channel | handshake                   | payload
// input   | i_in_valid / o_in_ready     | i_in_item  (action, value)
// output  | o_out_valid / i_out_ready   | o_out_item (status, echo_value)
//
// Insert and probe items walk the cell chain one cell per cycle; the result is registered once the
// token leaves the last cell. Clear and unused codes skip the chain and go straight to the result.
// One item walks at a time; o_in_ready is high only while idle.
// Reset is synchronous, active low, and empties the set at once.
// A stalled output holds its result; the next result waits inside until that one is taken.
module distinct_set_intersection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dsi_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dsi_pkg::t_out_item o_out_item
);
    import dsi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_tok      r_inj;
    t_tok      n_inj;
    t_bcast    r_bc;
    t_bcast    n_bc;
    t_out_item r_res;
    t_out_item n_res;
    logic      r_out_vld;
    logic      n_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    t_tok w_tok [CAPACITY+1];
    t_tok w_tail;
    logic w_in_acc;

    assign w_tok[0] = r_inj;
    assign w_tail   = w_tok[CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            dsi_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[g]),
                .i_bc    (r_bc),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_state   = r_state;
        n_inj     = r_inj;
        n_bc      = '0;
        n_res     = r_res;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_inj.vld = 1'b0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_item.action)
                        ACT_INSERT, ACT_PROBE: begin
                            n_inj.vld    = 1'b1;
                            n_inj.is_ins = (i_in_item.action == ACT_INSERT);
                            n_inj.hit    = 1'b0;
                            n_inj.placed = 1'b0;
                            n_inj.val    = i_in_item.value;
                            n_state      = S_WALK;
                        end
                        ACT_CLEAR: begin
                            n_bc.clr_all = 1'b1;
                            n_res        = '{status: ST_OK, echo_value: '0};
                            n_state      = S_DONE;
                        end
                        default: begin
                            n_res   = '{status: ST_OK, echo_value: '0};
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_tail.vld) begin
                    n_bc.fin         = 1'b1;
                    n_bc.cancel      = w_tail.is_ins && w_tail.hit && w_tail.placed;
                    n_res.echo_value = w_tail.val;
                    if (w_tail.is_ins) begin
                        n_res.status = (w_tail.hit || w_tail.placed) ? ST_OK : ST_FULL;
                    end else begin
                        n_res.status = w_tail.hit ? ST_MATCH : ST_ABSENT;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_inj     <= '0;
            r_bc      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inj     <= n_inj;
            r_bc      <= n_bc;
            r_out_vld <= n_out_vld;
        end
    end

`ifndef SYNTHESIS
    a_tail_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.vld |-> (r_state == S_WALK))
        else $error("token left the chain outside a walk");

    a_bcast_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_bc.fin && r_bc.clr_all))
        else $error("finish and clear broadcast together");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("block stayed idle after taking an item");

    a_clear_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_item.action == ACT_CLEAR)) |=> r_bc.clr_all)
        else $error("clear item did not empty the set");

    a_cancel_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc.cancel |-> r_bc.fin)
        else $error("cancel without finish");
`endif

endmodule
